/* rtl/nnfs_pkg.sv */
// Shared widths, register indexes, reset values and control structures
// for the nearest-neighbour frame scaler. No dependencies.
package nnfs_pkg;

    // Field widths fixed by the external interface.
    localparam int SRC_W       = 12;   // source frame sizes
    localparam int DST_W       = 13;   // destination frame sizes
    localparam int COORD_W     = 12;   // destination coordinates
    localparam int PIX_W       = 8;    // pen index
    localparam int ADDR_IN_W   = 16;   // linear write address
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 13;

    // Parameter defaults.
    localparam int DEF_FRAME_PIXELS = 65536;
    localparam int DEF_FRAC_BITS    = 16;

    // Item commands.
    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_READ  = 1'b1;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_W-1:0] REG_SOURCE_WIDTH  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_SOURCE_HEIGHT = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_TARGET_WIDTH  = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_TARGET_HEIGHT = 2'd3;

    // Register values after reset.
    localparam logic [SRC_W-1:0] RST_SOURCE_WIDTH  = 12'd320;
    localparam logic [SRC_W-1:0] RST_SOURCE_HEIGHT = 12'd200;
    localparam logic [DST_W-1:0] RST_TARGET_WIDTH  = 13'd640;
    localparam logic [DST_W-1:0] RST_TARGET_HEIGHT = 13'd400;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic cfg_write;
        logic div_start;
        logic mem_wr_en;
        logic read_capture;
        logic mul_en;
        logic lin_en;
        logic mem_rd_en;
        logic out_load;
    } nnfs_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic div_busy;
    } nnfs_status_t;

endpackage

/* rtl/nnfs_step_div.sv */
// Restoring divider that derives both fixed-point scale steps, one
// quotient bit per cycle for each axis. Depends on nnfs_pkg.
module nnfs_step_div #(
    parameter int FRAC_BITS = nnfs_pkg::DEF_FRAC_BITS
) (
    input  logic                                      clk,
    input  logic                                      rst_n,
    input  logic                                      start,
    input  logic [nnfs_pkg::SRC_W-1:0]                src_x,
    input  logic [nnfs_pkg::SRC_W-1:0]                src_y,
    input  logic [nnfs_pkg::DST_W-1:0]                dst_x,
    input  logic [nnfs_pkg::DST_W-1:0]                dst_y,
    output logic                                      busy,
    output logic [nnfs_pkg::SRC_W+FRAC_BITS-1:0]      x_step,
    output logic [nnfs_pkg::SRC_W+FRAC_BITS-1:0]      y_step
);
    import nnfs_pkg::*;

    localparam int STEP_W = SRC_W + FRAC_BITS;
    localparam int CNT_W  = $clog2(STEP_W + 1);
    localparam logic [STEP_W-1:0] RST_X_STEP =
        STEP_W'((longint'(RST_SOURCE_WIDTH) << FRAC_BITS) / RST_TARGET_WIDTH);
    localparam logic [STEP_W-1:0] RST_Y_STEP =
        STEP_W'((longint'(RST_SOURCE_HEIGHT) << FRAC_BITS) / RST_TARGET_HEIGHT);

    logic [DST_W-1:0]  rem_x_reg, rem_x_next;
    logic [DST_W-1:0]  rem_y_reg, rem_y_next;
    logic [STEP_W-1:0] quo_x_reg, quo_x_next;
    logic [STEP_W-1:0] quo_y_reg, quo_y_next;
    logic [STEP_W-1:0] x_step_reg, y_step_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic              busy_reg;

    // One restoring step: the dividend bits shift out of the top of the
    // quotient register while quotient bits shift in at the bottom.
    function automatic logic [DST_W+STEP_W-1:0] div_step(
        input logic [DST_W-1:0]  rem,
        input logic [STEP_W-1:0] quo,
        input logic [DST_W-1:0]  divisor
    );
        logic [DST_W:0] trial;
        logic [DST_W:0] diff;
        trial = {rem, quo[STEP_W-1]};
        diff  = trial - {1'b0, divisor};
        if (trial >= {1'b0, divisor})
        begin
            return {diff[DST_W-1:0], quo[STEP_W-2:0], 1'b1};
        end
        return {trial[DST_W-1:0], quo[STEP_W-2:0], 1'b0};
    endfunction

    always_comb
    begin
        {rem_x_next, quo_x_next} = div_step(rem_x_reg, quo_x_reg, dst_x);
        {rem_y_next, quo_y_next} = div_step(rem_y_reg, quo_y_reg, dst_y);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg   <= 1'b0;
            cnt_reg    <= '0;
            x_step_reg <= RST_X_STEP;
            y_step_reg <= RST_Y_STEP;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= CNT_W'(STEP_W);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_reg <= 1'b0;
                // A zero destination size yields a zero step.
                x_step_reg <= (dst_x == '0) ? '0 : quo_x_next;
                y_step_reg <= (dst_y == '0) ? '0 : quo_y_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_x_reg <= '0;
            rem_y_reg <= '0;
            quo_x_reg <= {src_x, {FRAC_BITS{1'b0}}};
            quo_y_reg <= {src_y, {FRAC_BITS{1'b0}}};
        end
        else if (busy_reg)
        begin
            rem_x_reg <= rem_x_next;
            rem_y_reg <= rem_y_next;
            quo_x_reg <= quo_x_next;
            quo_y_reg <= quo_y_next;
        end
    end

    assign busy   = busy_reg;
    assign x_step = x_step_reg;
    assign y_step = y_step_reg;

    a_start_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> !busy_reg)
        else $error("step division restarted while still running");

    a_busy_has_count: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> cnt_reg != '0)
        else $error("divider busy with an exhausted bit count");

endmodule

/* rtl/nnfs_datapath.sv */
// Datapath: configuration registers, step divider, coordinate multipliers,
// frame memory and result register. Depends on nnfs_pkg and nnfs_step_div.
module nnfs_datapath #(
    parameter int FRAME_PIXELS = nnfs_pkg::DEF_FRAME_PIXELS,
    parameter int FRAC_BITS    = nnfs_pkg::DEF_FRAC_BITS
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  nnfs_pkg::nnfs_cmd_t                 cmd,
    output nnfs_pkg::nnfs_status_t              status,
    input  logic [nnfs_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [nnfs_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic [nnfs_pkg::ADDR_IN_W-1:0]      source_address,
    input  logic [nnfs_pkg::PIX_W-1:0]          pixel_value,
    input  logic [nnfs_pkg::COORD_W-1:0]        dest_x,
    input  logic [nnfs_pkg::COORD_W-1:0]        dest_y,
    output logic [nnfs_pkg::PIX_W-1:0]          pixel_out,
    output logic                                out_of_range
);
    import nnfs_pkg::*;

    localparam int STEP_W = SRC_W + FRAC_BITS;
    localparam int PROD_W = COORD_W + STEP_W;
    localparam int LIN_W  = 2 * SRC_W + 1;
    localparam int ADDR_W = $clog2(FRAME_PIXELS);
    localparam int WCMP_W = ((ADDR_W > ADDR_IN_W) ? ADDR_W : ADDR_IN_W) + 1;
    localparam logic [LIN_W-1:0]  FRAME_LIMIT_LIN = LIN_W'(FRAME_PIXELS);
    localparam logic [WCMP_W-1:0] FRAME_LIMIT_WR  = WCMP_W'(FRAME_PIXELS);

    logic [SRC_W-1:0]   source_width_reg, source_height_reg;
    logic [DST_W-1:0]   target_width_reg, target_height_reg;
    logic [STEP_W-1:0]  x_step, y_step;
    logic [COORD_W-1:0] dest_x_reg, dest_y_reg;
    logic [PROD_W-1:0]  x_prod, y_prod;
    logic [SRC_W-1:0]   col_reg, row_reg;
    logic               range_err_reg;
    logic [LIN_W-1:0]   lin_next, lin_reg;
    logic               err_reg;
    logic [WCMP_W-1:0]  wr_addr_ext;
    logic               wr_in_frame;
    logic [PIX_W-1:0]   rd_data_reg;
    logic [PIX_W-1:0]   pixel_out_reg;
    logic               out_of_range_reg;
    logic [PIX_W-1:0]   frame_mem [FRAME_PIXELS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            source_width_reg  <= RST_SOURCE_WIDTH;
            source_height_reg <= RST_SOURCE_HEIGHT;
            target_width_reg  <= RST_TARGET_WIDTH;
            target_height_reg <= RST_TARGET_HEIGHT;
        end
        else if (cmd.cfg_write)
        begin
            unique case (cfg_index)
                REG_SOURCE_WIDTH:  source_width_reg  <= cfg_data[SRC_W-1:0];
                REG_SOURCE_HEIGHT: source_height_reg <= cfg_data[SRC_W-1:0];
                REG_TARGET_WIDTH:  target_width_reg  <= cfg_data[DST_W-1:0];
                REG_TARGET_HEIGHT: target_height_reg <= cfg_data[DST_W-1:0];
                default: ;
            endcase
        end
    end

    nnfs_step_div #(
        .FRAC_BITS (FRAC_BITS)
    ) u_step_div (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (cmd.div_start),
        .src_x  (source_width_reg),
        .src_y  (source_height_reg),
        .dst_x  (target_width_reg),
        .dst_y  (target_height_reg),
        .busy   (status.div_busy),
        .x_step (x_step),
        .y_step (y_step)
    );

    assign x_prod   = PROD_W'(dest_x_reg) * PROD_W'(x_step);
    assign y_prod   = PROD_W'(dest_y_reg) * PROD_W'(y_step);
    assign lin_next = LIN_W'(row_reg) * LIN_W'(source_width_reg) + LIN_W'(col_reg);

    // Within the destination the mapped column stays below the source
    // width, so twelve bits above the binary point are enough.
    always_ff @(posedge clk)
    begin
        if (cmd.read_capture)
        begin
            dest_x_reg <= dest_x;
            dest_y_reg <= dest_y;
        end
        if (cmd.mul_en)
        begin
            col_reg       <= x_prod[FRAC_BITS +: SRC_W];
            row_reg       <= y_prod[FRAC_BITS +: SRC_W];
            range_err_reg <= (DST_W'(dest_x_reg) >= target_width_reg) ||
                             (DST_W'(dest_y_reg) >= target_height_reg);
        end
        if (cmd.lin_en)
        begin
            lin_reg <= lin_next;
        end
        if (cmd.mem_rd_en)
        begin
            err_reg <= range_err_reg || (lin_reg >= FRAME_LIMIT_LIN);
        end
        if (cmd.out_load)
        begin
            pixel_out_reg    <= err_reg ? '0 : rd_data_reg;
            out_of_range_reg <= err_reg;
        end
    end

    assign wr_addr_ext = WCMP_W'(source_address);
    assign wr_in_frame = wr_addr_ext < FRAME_LIMIT_WR;

    always_ff @(posedge clk)
    begin
        if (cmd.mem_wr_en && wr_in_frame)
        begin
            frame_mem[wr_addr_ext[ADDR_W-1:0]] <= pixel_value;
        end
        if (cmd.mem_rd_en)
        begin
            rd_data_reg <= frame_mem[lin_reg[ADDR_W-1:0]];
        end
    end

    assign pixel_out    = pixel_out_reg;
    assign out_of_range = out_of_range_reg;

endmodule

/* rtl/nnfs_ctrl.sv */
// Controller state machine: handshakes, step recomputation sequencing and
// the read sequence through the datapath. Depends on nnfs_pkg.
module nnfs_ctrl (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic                    command,
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    output logic                    out_valid,
    input  logic                    out_ready,
    output nnfs_pkg::nnfs_cmd_t     cmd,
    input  nnfs_pkg::nnfs_status_t  status
);
    import nnfs_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV_START,
        S_DIV_WAIT,
        S_MUL,
        S_LINEAR,
        S_MEM_READ,
        S_RESULT
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   in_accept, cfg_accept;

    // A configuration write wins over an item offered in the same cycle.
    assign cfg_ready  = (state_reg == S_IDLE);
    assign in_ready   = (state_reg == S_IDLE) && !cfg_valid;
    assign cfg_accept = cfg_valid && cfg_ready;
    assign in_accept  = in_valid && in_ready;

    always_comb
    begin
        cmd              = '0;
        cmd.cfg_write    = cfg_accept;
        cmd.mem_wr_en    = in_accept && (command == CMD_WRITE);
        cmd.read_capture = in_accept && (command == CMD_READ);
        cmd.div_start    = (state_reg == S_DIV_START);
        cmd.mul_en       = (state_reg == S_MUL);
        cmd.lin_en       = (state_reg == S_LINEAR);
        cmd.mem_rd_en    = (state_reg == S_MEM_READ);
        cmd.out_load     = (state_reg == S_RESULT) && (!out_valid_reg || out_ready);

        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (cfg_accept)
                begin
                    state_next = S_DIV_START;
                end
                else if (in_accept && (command == CMD_READ))
                begin
                    state_next = S_MUL;
                end
            end
            S_DIV_START: state_next = S_DIV_WAIT;
            S_DIV_WAIT:
            begin
                if (!status.div_busy)
                begin
                    state_next = S_IDLE;
                end
            end
            S_MUL:      state_next = S_LINEAR;
            S_LINEAR:   state_next = S_MEM_READ;
            S_MEM_READ: state_next = S_RESULT;
            S_RESULT:
            begin
                if (cmd.out_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default:    state_next = S_IDLE;
        endcase

        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

    a_one_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |-> !(cfg_valid && cfg_ready))
        else $error("item and configuration write accepted together");

    a_div_seen_busy: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_start |=> status.div_busy)
        else $error("divider did not report busy after start");

endmodule

/* rtl/nearest_neighbor_frame_scaler.sv */
// Top level of the nearest-neighbour frame scaler: joins the controller
// and the datapath. Depends on nnfs_pkg, nnfs_ctrl and nnfs_datapath.
//
//  Channel  Handshake             Payload
//  in       in_valid/in_ready     command, source_address, pixel_value, dest_x, dest_y
//  out      out_valid/out_ready   pixel_out, out_of_range
//  cfg      cfg_valid/cfg_ready   cfg_index, cfg_data
//
// A pixel write leaves the controller idle; writes can be accepted in every cycle while
// no configuration write is offered. A read passes through multiply, linear address,
// memory read and result load, and no new item is taken until its result is loaded.
// A configuration write holds both ready signals low through the divider start and wait
// states while the bit-serial divider forms both steps.
// A read stalls in its last step only while the earlier result is still waiting.
// Reset restores the default sizes and steps; the frame memory is not cleared.
module nearest_neighbor_frame_scaler #(
    parameter int FRAME_PIXELS = nnfs_pkg::DEF_FRAME_PIXELS,
    parameter int FRAC_BITS    = nnfs_pkg::DEF_FRAC_BITS
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic                               command,
    input  logic [nnfs_pkg::ADDR_IN_W-1:0]     source_address,
    input  logic [nnfs_pkg::PIX_W-1:0]         pixel_value,
    input  logic [nnfs_pkg::COORD_W-1:0]       dest_x,
    input  logic [nnfs_pkg::COORD_W-1:0]       dest_y,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [nnfs_pkg::PIX_W-1:0]         pixel_out,
    output logic                               out_of_range,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [nnfs_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [nnfs_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import nnfs_pkg::*;

    nnfs_cmd_t    cmd;
    nnfs_status_t status;

    nnfs_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .command   (command),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd),
        .status    (status)
    );

    nnfs_datapath #(
        .FRAME_PIXELS (FRAME_PIXELS),
        .FRAC_BITS    (FRAC_BITS)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .status         (status),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .source_address (source_address),
        .pixel_value    (pixel_value),
        .dest_x         (dest_x),
        .dest_y         (dest_y),
        .pixel_out      (pixel_out),
        .out_of_range   (out_of_range)
    );

endmodule
